// File: rtl/lle_pkg.sv
// shared types, constants and the illumination table for the low-light enhancer
`default_nettype none
package lle_pkg;

	localparam int unsigned LLE_MAX_WIDTH = 4096;
	localparam int unsigned LLE_DEF_WIDTH = 640;
	localparam int unsigned LLE_DEF_HEIGHT = 480;
	localparam int unsigned LLE_ILLUM_FLOOR = 655;

	// register map by word index
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} lle_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} lle_out_t;

	typedef logic [16:0] illum_rom_t [256];

	// round-to-nearest square root, evaluated at elaboration only
	function automatic longint unsigned rsqrt(input longint unsigned y);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 64'd1 << 18;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * (mid - 1) < y) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	// illumination per channel maximum, unsigned 1.16
	function automatic illum_rom_t build_illum_rom();
		illum_rom_t      rom;
		longint unsigned f;
		longint unsigned s;
		longint unsigned mm;
		for (int m = 0; m < 256; m++) begin
			mm = longint'(m);
			f = (mm * 131072 + 255) / 510;
			s = rsqrt(((mm << 33) + 255) / 510);
			if (m > 204) rom[m] = 17'(rsqrt(s * f));
			else rom[m] = 17'(s);
		end
		return rom;
	endfunction

	localparam illum_rom_t ILLUM_ROM = build_illum_rom();

endpackage
`default_nettype wire

// File: rtl/low_light_illumination_enhance.sv
// low-light enhancement: illumination table, 3x3 blur over line store, channel divide
// one beat at a time: the next beat is taken only back in idle, after the previous beat's result,
// if any, has left S_FIN; the pace is set by the 8-step divider and the single line-store port
// reset: counters cleared, width 640, height 480; the line store is not cleared
// and only entries written in the current frame feed a result
`default_nettype none
module low_light_illumination_enhance
	import lle_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = LLE_MAX_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire lle_in_t     pix,
	output logic             res_valid,
	input  wire logic        res_stall,
	output lle_out_t         res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = 58;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UPD  = 6'b000010,
		S_FLD  = 6'b000100,
		S_DSET = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	function automatic logic [18:0] vsum(input logic [16:0] t, input logic [16:0] m,
			input logic [16:0] b);
		return 19'(t) + {1'b0, m, 1'b0} + 19'(b);
	endfunction

	function automatic logic [16:0] blur3(input logic [18:0] vl, input logic [18:0] vc,
			input logic [18:0] vr);
		logic [21:0] sum;
		logic [17:0] v;
		sum = 22'(vl) + {2'b0, vc, 1'b0} + 22'(vr) + 22'd8;
		v = sum[21:4];
		if (v < 18'(LLE_ILLUM_FLOOR)) v = 18'(LLE_ILLUM_FLOOR);
		return v[16:0];
	endfunction

	state_t       state_q;
	logic [12:0]  fw_q, fh_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [12:0]  in_row_q, out_row_q;
	logic [16:0]  win_q [9];
	logic [23:0]  pw_q;
	logic [23:0]  pix_hold_q;
	logic [16:0]  illum_q;
	logic [2:0]   step_q;
	logic [18:0]  vl_q, vc_q;
	logic [23:0]  fpix_q;
	logic [16:0]  div_l_q;
	logic [23:0]  div_pix_q;
	logic         div_last_q;
	logic [25:0]  rem_q [3];
	logic [7:0]   quo_q [3];
	logic [2:0]   sat_q;
	lle_out_t     res_q;
	logic         res_valid_q;

	logic [WW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic          cfg_wr;
	logic          pix_acc;
	logic          emit_last;
	logic [CW-1:0] out_col_nx;
	logic [12:0]   out_row_nx;
	logic [CW-1:0] jl, jr;
	logic [CW-1:0] ram_addr;
	logic          ram_we;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [16:0]   rd_upper, rd_middle;
	logic [23:0]   rd_pixel;
	logic [16:0]   new_top;
	logic [18:0]   vo1, vo2, vn;
	logic [16:0]   edge_l, norm_l, last_l;
	logic          row_wrap_in, in_col_wrap;
	logic [12:0]   in_row_inc;
	logic [7:0]    mx;
	logic [25:0]   d_sh;
	logic          res_free;

	// effective frame size
	always_comb begin
		if (fw_q < 13'd2) w_eff = WW'(2);
		else if ({1'b0, fw_q} > 14'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(fw_q);
		if (fh_q < 13'd2) h_eff = 13'd2;
		else h_eff = fh_q;
	end

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(fh_q) : 32'(fw_q);

	assign pix_stall = (state_q != S_IDLE);
	assign pix_acc = pix_valid && !pix_stall;
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign res_free = !res_valid_q || !res_stall;

	// output position bookkeeping
	always_comb begin
		emit_last = (out_row_q == h_eff - 13'd1) && (WW'(out_col_q) == w_eff - WW'(1));
		out_col_nx = out_col_q + CW'(1);
		out_row_nx = out_row_q;
		if (WW'(out_col_q) + WW'(1) >= w_eff) begin
			out_col_nx = '0;
			out_row_nx = (out_row_q + 13'd1 >= h_eff) ? 13'd0 : out_row_q + 13'd1;
		end
	end

	// input position advance
	assign in_col_wrap = (WW'(in_col_q) + WW'(1) >= w_eff);
	assign in_row_inc = in_row_q + 13'd1;
	assign row_wrap_in = (in_row_inc >= h_eff);

	// neighbors for the last-row drain
	assign jl = (out_col_q == '0) ? CW'(1) : out_col_q - CW'(1);
	assign jr = (WW'(out_col_q) == w_eff - WW'(1)) ? out_col_q - CW'(1) : out_col_q + CW'(1);

	// line store port
	assign rd_upper = ram_rdata[57:41];
	assign rd_middle = ram_rdata[40:24];
	assign rd_pixel = ram_rdata[23:0];
	assign ram_we = (state_q == S_UPD);
	assign ram_wdata = {rd_middle, illum_q, pix_hold_q};
	always_comb begin
		ram_addr = in_col_q;
		if (state_q == S_FLD) begin
			priority case (step_q)
				3'd0: ram_addr = jl;
				3'd1: ram_addr = out_col_q;
				default: ram_addr = jr;
			endcase
		end
	end

	lle_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_line (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// blur candidates
	assign new_top = (in_row_q == 13'd1) ? illum_q : rd_upper;
	assign vo1 = vsum(win_q[3], win_q[4], win_q[5]);
	assign vo2 = vsum(win_q[6], win_q[7], win_q[8]);
	assign vn = vsum(new_top, rd_middle, illum_q);
	assign edge_l = blur3(vo1, vo2, vo1);
	assign norm_l = blur3((in_col_q == CW'(1)) ? vn : vo1, vo2, vn);
	assign last_l = blur3(vl_q, vc_q, vsum(rd_upper, rd_middle, rd_upper));

	// channel maximum
	always_comb begin
		mx = (pix.red_in > pix.green_in) ? pix.red_in : pix.green_in;
		if (pix.blue_in > mx) mx = pix.blue_in;
	end

	assign d_sh = 26'({div_l_q, 1'b0}) << step_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fw_q <= 13'(LLE_DEF_WIDTH);
			fh_q <= 13'(LLE_DEF_HEIGHT);
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			step_q <= '0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
			pw_q <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_FRAME_WIDTH) fw_q <= pwdata[12:0];
				else fh_q <= pwdata[12:0];
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
			// result register handshake
			if (state_q == S_FIN && res_free) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						if (!pix.operation) begin
							pix_hold_q <= {pix.blue_in, pix.green_in, pix.red_in};
							illum_q <= ILLUM_ROM[mx];
							state_q <= S_UPD;
						end else if (in_row_q == '0 && in_col_q == '0 &&
								!(out_row_q == '0 && out_col_q == '0)) begin
							if (out_row_q != h_eff - 13'd1) begin
								div_l_q <= edge_l;
								div_pix_q <= pw_q;
								div_last_q <= emit_last;
								out_col_q <= out_col_nx;
								out_row_q <= out_row_nx;
								state_q <= S_DSET;
							end else begin
								step_q <= '0;
								state_q <= S_FLD;
							end
						end
					end
				end
				S_UPD: begin
					// shift the window and take the new column
					for (int k = 0; k < 6; k++) win_q[k] <= win_q[k + 3];
					win_q[6] <= new_top;
					win_q[7] <= rd_middle;
					win_q[8] <= illum_q;
					pw_q <= rd_pixel;
					state_q <= S_IDLE;
					if (in_row_q == '0 && in_col_q == '0) begin
						out_col_q <= '0;
						out_row_q <= '0;
					end else if ((in_col_q == '0 && in_row_q >= 13'd2) ||
							(in_col_q != '0 && in_row_q != '0)) begin
						div_l_q <= (in_col_q == '0) ? edge_l : norm_l;
						div_pix_q <= pw_q;
						div_last_q <= emit_last;
						out_col_q <= out_col_nx;
						out_row_q <= out_row_nx;
						state_q <= S_DSET;
					end
					if (in_col_wrap) begin
						in_col_q <= '0;
						in_row_q <= row_wrap_in ? 13'd0 : in_row_inc;
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				S_FLD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) vl_q <= vsum(rd_upper, rd_middle, rd_upper);
					if (step_q == 3'd2) begin
						vc_q <= vsum(rd_upper, rd_middle, rd_upper);
						fpix_q <= rd_pixel;
					end
					if (step_q == 3'd3) begin
						div_l_q <= last_l;
						div_pix_q <= fpix_q;
						div_last_q <= emit_last;
						out_col_q <= out_col_nx;
						out_row_q <= out_row_nx;
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					// numerator c*2^17 + L, saturate when quotient passes 255
					for (int k = 0; k < 3; k++) begin
						rem_q[k] <= {1'b0, div_pix_q[8*k +: 8], 17'd0} + 26'(div_l_q);
						sat_q[k] <= ({1'b0, div_pix_q[8*k +: 8], 17'd0} + 26'(div_l_q)) >=
							{div_l_q, 9'd0};
						quo_q[k] <= '0;
					end
					step_q <= 3'd7;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit per cycle for all channels
					for (int k = 0; k < 3; k++) begin
						if (rem_q[k] >= d_sh) begin
							rem_q[k] <= rem_q[k] - d_sh;
							quo_q[k][step_q] <= 1'b1;
						end
					end
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						res_q.red_out <= sat_q[0] ? 8'hFF : quo_q[0];
						res_q.green_out <= sat_q[1] ? 8'hFF : quo_q[1];
						res_q.blue_out <= sat_q[2] ? 8'hFF : quo_q[2];
						res_q.frame_last <= div_last_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/lle_ram.sv
// generic single-port ram with registered read
`default_nettype none
module lle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first storage
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire
